### hdl/rbsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, constants and payload types of the ray / box slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    // fixed point format and derived widths
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;                 // field width
    localparam int QW        = DW + FRAC_BITS + 1; // quotient bits, divider stages
    localparam int TW        = QW + 2;             // signed distance incl. infinity
    localparam int PHW       = QW + 1 - DW;        // upper slice of |t|
    localparam int MW        = 2 * DW - FRAC_BITS + 1;
    localparam int OW        = DW + 3;             // signed offset width
    localparam int LATENCY   = QW + 7;

    // infinity sits above any finite distance
    localparam logic signed [TW-1:0] T_INF  = {2'b01, {QW{1'b0}}};
    localparam logic signed [TW-1:0] T_NINF = {2'b11, {QW{1'b0}}};

    // offset magnitude cap
    localparam logic [MW-1:0] OFF_CAP = MW'(64'd1 << (DW + 1));

    localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0] origin_x;
        logic signed [DW-1:0] origin_y;
        logic signed [DW-1:0] origin_z;
        logic signed [DW-1:0] dir_x;
        logic signed [DW-1:0] dir_y;
        logic signed [DW-1:0] dir_z;
        logic signed [DW-1:0] box_min_x;
        logic signed [DW-1:0] box_min_y;
        logic signed [DW-1:0] box_min_z;
        logic signed [DW-1:0] box_max_x;
        logic signed [DW-1:0] box_max_y;
        logic signed [DW-1:0] box_max_z;
    } rbsi_in_t;

    typedef struct packed {
        logic                 hit;
        logic signed [DW-1:0] hit_x;
        logic signed [DW-1:0] hit_y;
        logic signed [DW-1:0] hit_z;
    } rbsi_out_t;

    // data that rides alongside the dividers
    typedef struct packed {
        logic [2:0][DW-1:0] org;
        logic [2:0][DW-1:0] dir;
        logic [2:0]         dzero;
        logic [2:0]         neg_lo;
        logic [2:0]         neg_hi;
        logic               slab_ok;
    } rbsi_side_t;

endpackage
`default_nettype wire

### hdl/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle; busy is always low.
// The depth is set by the six bit-per-stage dividers (QW = 49 stages).
// Reset clears all valid bits; nothing in flight survives reset.
// The receiver cannot stall: each result is shown for one cycle with done.
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Fixed point ray / axis-aligned box slab test with entry point.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rbsi_pkg::rbsi_in_t req,
    output logic                    done,
    output rbsi_pkg::rbsi_out_t     rsp
);

    localparam int DW = rbsi_pkg::DW;
    localparam int QW = rbsi_pkg::QW;
    localparam int TW = rbsi_pkg::TW;

    logic signed [DW-1:0] o_in  [3];
    logic signed [DW-1:0] d_in  [3];
    logic signed [DW-1:0] lo_in [3];
    logic signed [DW-1:0] hi_in [3];

    logic [QW-1:0] num_lo_next [3];
    logic [QW-1:0] num_hi_next [3];
    logic [DW-1:0] den_next    [3];
    logic [2:0]    inrange;
    rbsi_pkg::rbsi_side_t side_a_next;

    logic                 vld_a_reg;
    logic [QW-1:0]        num_lo_reg [3];
    logic [QW-1:0]        num_hi_reg [3];
    logic [DW-1:0]        den_reg    [3];
    rbsi_pkg::rbsi_side_t side_a_reg;

    logic                 vld_reg  [QW];
    rbsi_pkg::rbsi_side_t side_reg [QW];

    logic [QW-1:0] quo_lo [3];
    logic [QW-1:0] quo_hi [3];

    logic signed [TW-1:0] t0_next [3];
    logic signed [TW-1:0] t1_next [3];
    logic signed [TW-1:0] t0_reg  [3];
    logic signed [TW-1:0] t1_reg  [3];
    logic                 vld_c_reg;
    rbsi_pkg::rbsi_side_t side_c_reg;

    logic signed [TW-1:0] tmin_next;
    logic signed [TW-1:0] tmax_next;
    logic signed [TW-1:0] tmin_reg;
    logic signed [TW-1:0] tmax_reg;
    logic                 vld_d_reg;
    rbsi_pkg::rbsi_side_t side_d_reg;

    logic [QW:0]          tm_next;
    logic [QW:0]          tm_reg;
    logic [2:0]           neg_e_reg;
    logic [DW-1:0]        dm_e_reg  [3];
    logic signed [DW-1:0] org_e_reg [3];
    logic                 ok_e_reg;
    logic                 vld_e_reg;

    logic                 ok_f_reg;
    logic                 vld_f_reg;
    logic                 ok_g_reg;
    logic                 vld_g_reg;
    logic signed [DW-1:0] pt [3];

    logic                 done_reg;
    rbsi_pkg::rbsi_out_t  rsp_reg;

    assign busy = 1'b0;

    assign o_in[0]  = req.origin_x;
    assign o_in[1]  = req.origin_y;
    assign o_in[2]  = req.origin_z;
    assign d_in[0]  = req.dir_x;
    assign d_in[1]  = req.dir_y;
    assign d_in[2]  = req.dir_z;
    assign lo_in[0] = req.box_min_x;
    assign lo_in[1] = req.box_min_y;
    assign lo_in[2] = req.box_min_z;
    assign hi_in[0] = req.box_max_x;
    assign hi_in[1] = req.box_max_y;
    assign hi_in[2] = req.box_max_z;

    // differences, magnitudes, signs and zero-direction checks
    always_comb
    begin
        logic signed [DW:0] dlo;
        logic signed [DW:0] dhi;
        logic [DW:0]        mlo;
        logic [DW:0]        mhi;
        for (int k = 0; k < 3; k++)
        begin
            dlo = (DW+1)'(lo_in[k]) - (DW+1)'(o_in[k]);
            dhi = (DW+1)'(hi_in[k]) - (DW+1)'(o_in[k]);
            mlo = dlo[DW] ? (DW+1)'(-dlo) : dlo;
            mhi = dhi[DW] ? (DW+1)'(-dhi) : dhi;
            num_lo_next[k] = {mlo, {rbsi_pkg::FRAC_BITS{1'b0}}};
            num_hi_next[k] = {mhi, {rbsi_pkg::FRAC_BITS{1'b0}}};
            den_next[k]    = d_in[k][DW-1] ? DW'(-d_in[k]) : d_in[k];
            inrange[k]     = ((o_in[k] >= lo_in[k]) && (o_in[k] <= hi_in[k]))
                          || ((o_in[k] >= hi_in[k]) && (o_in[k] <= lo_in[k]));
            side_a_next.org[k]    = o_in[k];
            side_a_next.dir[k]    = d_in[k];
            side_a_next.dzero[k]  = (d_in[k] == '0);
            side_a_next.neg_lo[k] = dlo[DW] ^ d_in[k][DW-1];
            side_a_next.neg_hi[k] = dhi[DW] ^ d_in[k][DW-1];
        end
        side_a_next.slab_ok = &(~side_a_next.dzero | inrange);
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_a_reg <= 1'b0;
        else
            vld_a_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_lo_reg[k] <= num_lo_next[k];
            num_hi_reg[k] <= num_hi_next[k];
            den_reg[k]    <= den_next[k];
        end
        side_a_reg <= side_a_next;
    end

    // six dividers
    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_axis
            rbsi_div u_div_lo (
                .clk (clk),
                .num (num_lo_reg[g]),
                .den (den_reg[g]),
                .quo (quo_lo[g])
            );
            rbsi_div u_div_hi (
                .clk (clk),
                .num (num_hi_reg[g]),
                .den (den_reg[g]),
                .quo (quo_hi[g])
            );
        end
    endgenerate

    // sideband delay line matched to the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= vld_a_reg;
            for (int k = 1; k < QW; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_a_reg;
        for (int k = 1; k < QW; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // signed distances, ordered, unbounded slabs
    always_comb
    begin
        logic signed [TW-1:0] ta;
        logic signed [TW-1:0] tb;
        for (int k = 0; k < 3; k++)
        begin
            ta = side_reg[QW-1].neg_lo[k] ? -$signed({2'b00, quo_lo[k]})
                                           : $signed({2'b00, quo_lo[k]});
            tb = side_reg[QW-1].neg_hi[k] ? -$signed({2'b00, quo_hi[k]})
                                           : $signed({2'b00, quo_hi[k]});
            if (side_reg[QW-1].dzero[k])
            begin
                t0_next[k] = rbsi_pkg::T_NINF;
                t1_next[k] = rbsi_pkg::T_INF;
            end
            else if (ta > tb)
            begin
                t0_next[k] = tb;
                t1_next[k] = ta;
            end
            else
            begin
                t0_next[k] = ta;
                t1_next[k] = tb;
            end
        end
    end

    // interval intersection
    always_comb
    begin
        tmin_next = t0_reg[0];
        tmax_next = t1_reg[0];
        for (int k = 1; k < 3; k++)
        begin
            if (t0_reg[k] > tmin_next)
                tmin_next = t0_reg[k];
            if (t1_reg[k] < tmax_next)
                tmax_next = t1_reg[k];
        end
    end

    assign tm_next = tmin_reg[TW-1] ? (QW+1)'(-tmin_reg) : tmin_reg[QW:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            vld_c_reg <= vld_reg[QW-1];
            vld_d_reg <= vld_c_reg;
            vld_e_reg <= vld_d_reg;
            vld_f_reg <= vld_e_reg;
            vld_g_reg <= vld_f_reg;
            done_reg  <= vld_g_reg;
        end
    end

    // distance, intersection and product staging
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            t0_reg[k] <= t0_next[k];
            t1_reg[k] <= t1_next[k];
        end
        side_c_reg <= side_reg[QW-1];

        tmin_reg   <= tmin_next;
        tmax_reg   <= tmax_next;
        side_d_reg <= side_c_reg;

        tm_reg   <= tm_next;
        ok_e_reg <= side_d_reg.slab_ok && (tmin_reg <= tmax_reg);
        for (int k = 0; k < 3; k++)
        begin
            neg_e_reg[k] <= tmin_reg[TW-1] ^ side_d_reg.dir[k][DW-1];
            dm_e_reg[k]  <= side_d_reg.dir[k][DW-1] ? DW'(-side_d_reg.dir[k])
                                                     : side_d_reg.dir[k];
            org_e_reg[k] <= side_d_reg.org[k];
        end

        ok_f_reg <= ok_e_reg;
        ok_g_reg <= ok_f_reg;

        rsp_reg.hit   <= ok_g_reg;
        rsp_reg.hit_x <= ok_g_reg ? pt[0] : '0;
        rsp_reg.hit_y <= ok_g_reg ? pt[1] : '0;
        rsp_reg.hit_z <= ok_g_reg ? pt[2] : '0;
    end

    // entry point per axis
    generate
        for (g = 0; g < 3; g++)
        begin : g_pt
            rbsi_point u_point (
                .clk (clk),
                .tm  (tm_reg),
                .dm  (dm_e_reg[g]),
                .neg (neg_e_reg[g]),
                .org (org_e_reg[g]),
                .pt  (pt[g])
            );
        end
    endgenerate

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    // every accepted transaction comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(rbsi_pkg::LATENCY) done)
        else $error("result missing after fixed latency");

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.hit) |-> (rsp.hit_x == '0 && rsp.hit_y == '0 && rsp.hit_z == '0))
        else $error("miss with nonzero point");

    // pipeline carries the item through the middle stages
    a_mid_valid: assert property (@(posedge clk) disable iff (!rst_n)
        vld_c_reg |-> ##5 done)
        else $error("valid lost in output stages");
`endif

endmodule
`default_nettype wire

### hdl/rbsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_div (
    input  wire logic                      clk,
    input  wire logic [rbsi_pkg::QW-1:0]   num,
    input  wire logic [rbsi_pkg::DW-1:0]   den,
    output logic      [rbsi_pkg::QW-1:0]   quo
);

    logic [rbsi_pkg::DW-1:0] rem_reg [rbsi_pkg::QW];
    logic [rbsi_pkg::QW-1:0] num_reg [rbsi_pkg::QW];
    logic [rbsi_pkg::QW-1:0] quo_reg [rbsi_pkg::QW];
    logic [rbsi_pkg::DW-1:0] den_reg [rbsi_pkg::QW];

    genvar k;
    generate
        for (k = 0; k < rbsi_pkg::QW; k++)
        begin : g_stage
            logic [rbsi_pkg::DW-1:0] rem_in;
            logic [rbsi_pkg::QW-1:0] num_in;
            logic [rbsi_pkg::QW-1:0] quo_in;
            logic [rbsi_pkg::DW-1:0] den_in;
            logic [rbsi_pkg::DW:0]   trial;
            logic                    ge;
            logic [rbsi_pkg::DW-1:0] rem_next;
            logic [rbsi_pkg::QW-1:0] num_next;
            logic [rbsi_pkg::QW-1:0] quo_next;

            // stage inputs
            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = num;
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign num_in = num_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            // shift in next numerator bit, trial subtract
            always_comb
            begin
                trial    = {rem_in, num_in[rbsi_pkg::QW-1]};
                ge       = (trial >= {1'b0, den_in});
                rem_next = ge ? rbsi_pkg::DW'(trial - {1'b0, den_in})
                              : trial[rbsi_pkg::DW-1:0];
                num_next = {num_in[rbsi_pkg::QW-2:0], 1'b0};
                quo_next = {quo_in[rbsi_pkg::QW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= num_next;
                quo_reg[k] <= quo_next;
                den_reg[k] <= den_in;
            end
        end
    endgenerate

    assign quo = quo_reg[rbsi_pkg::QW-1];

endmodule
`default_nettype wire

### hdl/rbsi_point.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_point
// One axis of the entry point: |t| * |d| in two partial products, shift,
// cap, sign, then origin plus offset saturated to 32 bits.
// ----------------------------------------------------------------------------
module rbsi_point (
    input  wire logic                          clk,
    input  wire logic [rbsi_pkg::QW:0]         tm,
    input  wire logic [rbsi_pkg::DW-1:0]       dm,
    input  wire logic                          neg,
    input  wire logic signed [rbsi_pkg::DW-1:0] org,
    output logic signed [rbsi_pkg::DW-1:0]     pt
);

    logic [2*rbsi_pkg::DW-1:0]             plo_reg;
    logic [rbsi_pkg::PHW+rbsi_pkg::DW-1:0] phi_reg;
    logic                                  neg_f_reg;
    logic signed [rbsi_pkg::DW-1:0]        org_f_reg;

    logic                                  cap;
    logic [rbsi_pkg::MW-1:0]               mag;
    logic [rbsi_pkg::MW-1:0]               mag_c;
    logic signed [rbsi_pkg::OW-1:0]        off_next;
    logic signed [rbsi_pkg::OW-1:0]        off_reg;
    logic signed [rbsi_pkg::DW-1:0]        org_g_reg;
    logic signed [rbsi_pkg::OW-1:0]        sum;

    // partial products
    always_ff @(posedge clk)
    begin
        plo_reg   <= tm[rbsi_pkg::DW-1:0] * dm;
        phi_reg   <= tm[rbsi_pkg::QW:rbsi_pkg::DW] * dm;
        neg_f_reg <= neg;
        org_f_reg <= org;
    end

    // recombine, truncate, cap and sign the offset
    always_comb
    begin
        cap   = |phi_reg[rbsi_pkg::PHW+rbsi_pkg::DW-1:rbsi_pkg::PHW];
        mag   = (rbsi_pkg::MW'(phi_reg[rbsi_pkg::PHW-1:0])
                    << (rbsi_pkg::DW - rbsi_pkg::FRAC_BITS))
              + rbsi_pkg::MW'(plo_reg >> rbsi_pkg::FRAC_BITS);
        mag_c = (cap || (mag > rbsi_pkg::OFF_CAP)) ? rbsi_pkg::OFF_CAP : mag;
        off_next = neg_f_reg ? -$signed(rbsi_pkg::OW'(mag_c))
                             : $signed(rbsi_pkg::OW'(mag_c));
    end

    always_ff @(posedge clk)
    begin
        off_reg   <= off_next;
        org_g_reg <= org_f_reg;
    end

    // add to origin and saturate
    always_comb
    begin
        sum = rbsi_pkg::OW'(org_g_reg) + off_reg;
        if (sum > rbsi_pkg::OW'(rbsi_pkg::S_MAX))
            pt = rbsi_pkg::S_MAX;
        else if (sum < rbsi_pkg::OW'(rbsi_pkg::S_MIN))
            pt = rbsi_pkg::S_MIN;
        else
            pt = sum[rbsi_pkg::DW-1:0];
    end

endmodule
`default_nettype wire
